>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bit packer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BPK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bit packer assertion failed");

`endif

>>> rtl/core/bpk_pkg.sv
// ----------------------------------------------------------------------------
// bpk_pkg
// Types and constants shared by the MSB-first bit packer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bpk_pkg;

    localparam int unsigned ACC_W  = 32;
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned CAP_W  = 25;
    localparam int unsigned IDX_W  = 24;
    localparam int unsigned BYTE_W = 8;

    localparam logic [CAP_W-1:0] MAX_CAPACITY = 25'h100_0000;
    localparam logic [LEN_W-1:0] ACC_BITS     = 6'd32;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_COUNT = 2'd2;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_OVERFLOW = 2'd1;
    localparam logic [1:0] KIND_COUNT    = 2'd2;

    localparam logic [1:0] CFG_COUNT_ONLY = 2'd0;
    localparam logic [1:0] CFG_CAPACITY   = 2'd1;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [ACC_W-1:0] data_value;
        logic [LEN_W-1:0] bit_length;
    } item_t;

    typedef struct packed {
        logic             count_only;
        logic [CAP_W-1:0] capacity_bytes;
    } cfg_t;

    // One burst of results: up to four bytes of word, or a single
    // overflow or count result.
    typedef struct packed {
        logic [1:0]       kind;
        logic [ACC_W-1:0] word;
        logic [2:0]       count;
        logic [IDX_W-1:0] base_index;
        logic [ACC_W-1:0] total;
    } burst_t;

endpackage

`default_nettype wire

>>> rtl/core/bpk_step_core.sv
// ----------------------------------------------------------------------------
// bpk_step_core
// Packer state and the single-pass update for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module bpk_step_core
    import bpk_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   fire,
    input  wire item_t  item,
    input  wire cfg_t   cfg,
    output logic        burst_valid,
    output burst_t      burst
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [LEN_W-1:0] free_reg, free_next;
    logic [CAP_W-1:0] wpos_reg, wpos_next;
    logic [ACC_W-1:0] cnt_reg, cnt_next;

    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] free_now;
    logic [CAP_W-1:0] cap_eff;
    logic [ACC_W-1:0] mask;
    logic [ACC_W-1:0] masked;
    logic [LEN_W-1:0] shift_in;
    logic [LEN_W-1:0] rest;
    logic [ACC_W-1:0] fill_word;
    logic [ACC_W-1:0] acc_after_fill;
    logic [LEN_W-1:0] used_bits;
    logic [LEN_W-1:0] used_round;
    logic [2:0]       nbytes;
    logic             ovf_fill;
    logic             ovf_flush;

    always_comb
    begin
        len_eff   = (item.bit_length > ACC_BITS) ? ACC_BITS : item.bit_length;
        free_now  = (free_reg == '0 || free_reg > ACC_BITS) ? ACC_BITS : free_reg;
        cap_eff   = (cfg.capacity_bytes > MAX_CAPACITY) ? MAX_CAPACITY : cfg.capacity_bytes;
        // A zero length shifts the mask out entirely; that case emits nothing.
        mask      = 32'hFFFF_FFFF >> (ACC_BITS - len_eff);
        masked    = item.data_value & mask;
        shift_in  = free_now - len_eff;
        rest      = len_eff - free_now;
        fill_word = acc_reg | (masked >> rest);
        acc_after_fill = (rest == '0) ? '0 : (masked << (ACC_BITS - rest));
        used_bits  = ACC_BITS - free_now;
        used_round = used_bits + 6'd7;
        nbytes     = used_round[5:3];
        ovf_fill   = ({1'b0, wpos_reg} + 26'd4) > {1'b0, cap_eff};
        ovf_flush  = ({1'b0, wpos_reg} + {23'b0, nbytes}) > {1'b0, cap_eff};
    end

    always_comb
    begin
        acc_next   = acc_reg;
        free_next  = free_reg;
        wpos_next  = wpos_reg;
        cnt_next   = cnt_reg;
        burst_valid = 1'b0;
        burst.kind       = KIND_BYTE;
        burst.word       = '0;
        burst.count      = 3'd1;
        burst.base_index = wpos_reg[IDX_W-1:0];
        burst.total      = '0;
        case (item.opcode)
            OP_WRITE:
            begin
                if (len_eff != '0)
                begin
                    if (cfg.count_only)
                    begin
                        cnt_next = cnt_reg + {26'b0, len_eff};
                    end
                    else if (len_eff < free_now)
                    begin
                        acc_next  = acc_reg | (masked << shift_in);
                        free_next = shift_in;
                    end
                    else if (ovf_fill)
                    begin
                        burst_valid = 1'b1;
                        burst.kind  = KIND_OVERFLOW;
                    end
                    else
                    begin
                        burst_valid = 1'b1;
                        burst.word  = fill_word;
                        burst.count = 3'd4;
                        acc_next    = acc_after_fill;
                        free_next   = ACC_BITS - rest;
                        wpos_next   = wpos_reg + 25'd4;
                    end
                end
            end
            OP_FLUSH:
            begin
                if (nbytes == '0)
                begin
                    acc_next  = '0;
                    free_next = ACC_BITS;
                end
                else if (ovf_flush)
                begin
                    burst_valid = 1'b1;
                    burst.kind  = KIND_OVERFLOW;
                end
                else
                begin
                    burst_valid = 1'b1;
                    burst.word  = acc_reg;
                    burst.count = nbytes;
                    acc_next    = '0;
                    free_next   = ACC_BITS;
                    wpos_next   = wpos_reg + {22'b0, nbytes};
                end
            end
            OP_COUNT:
            begin
                burst_valid      = 1'b1;
                burst.kind       = KIND_COUNT;
                burst.base_index = '0;
                burst.total      = cnt_reg;
            end
            default:
            begin
                burst_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            free_reg <= ACC_BITS;
            wpos_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (fire)
        begin
            acc_reg  <= acc_next;
            free_reg <= free_next;
            wpos_reg <= wpos_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bpk_emitter.sv
// ----------------------------------------------------------------------------
// bpk_emitter
// Result register that drains a burst one result per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bpk_emitter
    import bpk_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire burst_t           burst,
    output logic                  can_load,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [1:0]            result_kind,
    output logic [BYTE_W-1:0]     out_byte,
    output logic [IDX_W-1:0]      byte_index,
    output logic [ACC_W-1:0]      bit_total,
    output logic                  last
);

    logic             busy_reg, busy_next;
    logic [2:0]       left_reg, left_next;
    logic [1:0]       kind_reg, kind_next;
    logic [ACC_W-1:0] word_reg, word_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [ACC_W-1:0] total_reg, total_next;
    logic             out_fire;
    logic             final_fire;

    always_comb
    begin
        out_fire   = busy_reg && out_ready;
        final_fire = out_fire && (left_reg == 3'd1);
        can_load   = !busy_reg || final_fire;

        busy_next  = busy_reg;
        left_next  = left_reg;
        kind_next  = kind_reg;
        word_next  = word_reg;
        idx_next   = idx_reg;
        total_next = total_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            left_next  = burst.count;
            kind_next  = burst.kind;
            word_next  = burst.word;
            idx_next   = burst.base_index;
            total_next = burst.total;
        end
        else if (final_fire)
        begin
            busy_next = 1'b0;
        end
        else if (out_fire)
        begin
            left_next = left_reg - 3'd1;
            word_next = {word_reg[ACC_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            idx_next  = idx_reg + 24'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        word_reg  <= word_next;
        idx_reg   <= idx_next;
        total_reg <= total_next;
    end

    assign out_valid   = busy_reg;
    assign result_kind = kind_reg;
    assign out_byte    = (kind_reg == KIND_BYTE) ? word_reg[ACC_W-1:ACC_W-BYTE_W] : '0;
    assign byte_index  = idx_reg;
    assign bit_total   = total_reg;
    assign last        = (left_reg == 3'd1);

endmodule

`default_nettype wire

>>> rtl/core/msb_first_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer_unit
// Packs 1 to 32 bit codes MSB-first into bytes, with flush and bit count.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_ready   | opcode, data_value, bit_length
//  out     | output    | out_valid / out_ready | result_kind, out_byte, byte_index,
//          |           |                       | bit_total, last
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Items wait in the input register until the single result register can load;
// an item's results (up to four for a full word or flush) then leave one per
// accepted output transfer, while the next item waits in the input register.
// Reset clears the packer state, the configuration and the valid flags; no clearing pass is needed.
// A stalled output holds the burst, and the input register then fills and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_first_bit_packer_unit
    import bpk_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        opcode,
    input  wire logic [ACC_W-1:0]  data_value,
    input  wire logic [LEN_W-1:0]  bit_length,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             result_kind,
    output logic [BYTE_W-1:0]      out_byte,
    output logic [IDX_W-1:0]       byte_index,
    output logic [ACC_W-1:0]       bit_total,
    output logic                   last,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [CAP_W-1:0]  cfg_data
);

    cfg_t   cfg_reg;
    logic   item_vld_reg;
    item_t  item_reg;
    logic   burst_valid;
    burst_t burst;
    logic   can_load;
    logic   core_fire;

    assign cfg_ready = 1'b1;
    assign core_fire = item_vld_reg && can_load;
    assign in_ready  = !item_vld_reg || core_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count_only     <= 1'b0;
            cfg_reg.capacity_bytes <= MAX_CAPACITY;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COUNT_ONLY: cfg_reg.count_only     <= cfg_data[0];
                CFG_CAPACITY:   cfg_reg.capacity_bytes <= cfg_data;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.opcode     <= opcode;
            item_reg.data_value <= data_value;
            item_reg.bit_length <= bit_length;
        end
    end

    bpk_step_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (core_fire),
        .item        (item_reg),
        .cfg         (cfg_reg),
        .burst_valid (burst_valid),
        .burst       (burst)
    );

    bpk_emitter u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (core_fire && burst_valid),
        .burst       (burst),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .out_byte    (out_byte),
        .byte_index  (byte_index),
        .bit_total   (bit_total),
        .last        (last)
    );

endmodule

`default_nettype wire

>>> rtl/core/bpk_checker.sv
// ----------------------------------------------------------------------------
// bpk_checker
// Port-level checks on the bit packer output stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bpk_checker
    import bpk_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic [1:0]        result_kind,
    input  wire logic [BYTE_W-1:0] out_byte,
    input  wire logic [IDX_W-1:0]  byte_index,
    input  wire logic [ACC_W-1:0]  bit_total,
    input  wire logic              last
);

    logic out_fire;
    assign out_fire = out_valid && out_ready;

    `BPK_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_kind))
    `BPK_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_byte) && $stable(byte_index) && $stable(bit_total) && $stable(last))
    // Overflow and count reports are always a single result.
    `BPK_ASSERT_IMP(a_single_last, out_valid && (result_kind == KIND_OVERFLOW || result_kind == KIND_COUNT), last)
    // Bytes of one burst follow back to back at consecutive positions.
    `BPK_ASSERT_NXT(a_burst_seq, out_fire && result_kind == KIND_BYTE && !last, out_valid && result_kind == KIND_BYTE && byte_index == IDX_W'($past(byte_index) + 24'd1))
    `BPK_ASSERT_IMP(a_no_byte_data, out_valid && result_kind != KIND_BYTE, out_byte == '0 && (result_kind == KIND_COUNT || bit_total == '0))

endmodule

bind msb_first_bit_packer_unit bpk_checker u_bpk_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .out_byte    (out_byte),
    .byte_index  (byte_index),
    .bit_total   (bit_total),
    .last        (last)
);

`default_nettype wire
